FILE: hw/rtl/sabc_pkg.sv
package sabc_pkg;

  // Sample width of the converter front end.
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_SENSORS = 7;

  // Register widths.
  localparam int THRESH_W   = 10;
  localparam int PRES_W     = 13;
  localparam int WEIGHT_W   = 10;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths.
  localparam int TOTAL_W     = SAMPLE_BITS + 3;
  localparam int PROD_W      = SAMPLE_BITS + WEIGHT_W;
  localparam int MAG_W       = PROD_W + 2;
  localparam int SUM_W       = MAG_W + 1;
  localparam int QUOT_W      = 10;
  localparam int BEARING_W   = 11;
  localparam int OUT_TOTAL_W = 13;
  localparam int TCMP_W      = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam int CMP_W       = ((TOTAL_W > OUT_TOTAL_W) ? TOTAL_W : OUT_TOTAL_W) + 1;

  // Lanes subject to the low cut (left front, rear, right front, right spike).
  localparam logic [NUM_SENSORS-1:0] LANE_CUT = 7'b0111100;
  // Lanes whose bearing lies on the left and is negated.
  localparam logic [NUM_SENSORS-1:0] LANE_NEG = 7'b0000011;

  // Register reset values.
  localparam logic [THRESH_W-1:0] RST_LOW_CUT  = 10'd93;
  localparam logic [PRES_W-1:0]   RST_PRESENCE = 13'd5;
  localparam logic [WEIGHT_W-1:0] RST_WIDE     = 10'd246;
  localparam logic [WEIGHT_W-1:0] RST_SPIKE    = 10'd123;
  localparam logic [WEIGHT_W-1:0] RST_BACK     = 10'd804;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_CUT  = 3'd0,
    CFG_PRESENCE = 3'd1,
    CFG_WIDE     = 3'd2,
    CFG_SPIKE    = 3'd3,
    CFG_BACK     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] wide_left;
    logic [SAMPLE_BITS-1:0] left_spike;
    logic [SAMPLE_BITS-1:0] left_front;
    logic [SAMPLE_BITS-1:0] rear;
    logic [SAMPLE_BITS-1:0] right_front;
    logic [SAMPLE_BITS-1:0] right_spike;
    logic [SAMPLE_BITS-1:0] wide_right;
  } in_item_t;

  typedef struct packed {
    logic signed [BEARING_W-1:0] bearing;
    logic                        target_seen;
    logic [OUT_TOTAL_W-1:0]      sample_total;
  } out_item_t;

  // Merged lane results handed to the divider.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [TOTAL_W-1:0]      total;
    logic                    seen;
    logic [OUT_TOTAL_W-1:0]  total_sat;
  } merge_t;

  // One stage of the divider pipeline.
  typedef struct packed {
    logic [MAG_W-1:0]       rem;
    logic [TOTAL_W-1:0]     total;
    logic                   nz;
    logic                   neg;
    logic [QUOT_W-1:0]      quot;
    logic                   seen;
    logic [OUT_TOTAL_W-1:0] total_sat;
  } div_stage_t;

endpackage

FILE: hw/rtl/sensor_array_bearing_centroid.sv
// Bearing estimate from one scan of a seven-sensor light array. Each item is a
// scan of seven samples; the block returns exactly one result per item, the
// weighted mean bearing in Q8 radians (zero when all samples are zero), the
// presence flag and the thresholded sample total. The block takes a new item
// in every cycle and never raises busy. Each result appears on out_item for
// exactly one cycle, marked by out_valid, after the item passes the sensor
// lanes, the merging adder tree, the sign split, the pipelined restoring
// divider (one quotient bit per stage) and the output register. The receiver
// cannot stall the block, so it must take every strobed result. Configuration
// registers may be written only while no item is in flight.

module sensor_array_bearing_centroid (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  sabc_pkg::in_item_t               in_item,
  output logic                             out_valid,
  output sabc_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [sabc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sabc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sabc_pkg::*;

  localparam int LATENCY = 1 + 2 + 1 + QUOT_W + 1;

  // Configuration registers.
  logic [THRESH_W-1:0] low_cut_r;
  logic [PRES_W-1:0]   presence_r;
  logic [WEIGHT_W-1:0] wide_w_r;
  logic [WEIGHT_W-1:0] spike_w_r;
  logic [WEIGHT_W-1:0] back_w_r;

  logic [SAMPLE_BITS-1:0] samp        [NUM_SENSORS];
  logic [WEIGHT_W-1:0]    lane_weight [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] lane_samp   [NUM_SENSORS];
  logic [PROD_W-1:0]      lane_prod   [NUM_SENSORS];
  logic                   lane_vld_r;
  logic                   merge_vld;
  merge_t                 merge_data;

  // Every cycle can take an item.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cut_r  <= RST_LOW_CUT;
      presence_r <= RST_PRESENCE;
      wide_w_r   <= RST_WIDE;
      spike_w_r  <= RST_SPIKE;
      back_w_r   <= RST_BACK;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LOW_CUT:  low_cut_r  <= cfg_wdata[THRESH_W-1:0];
        CFG_PRESENCE: presence_r <= cfg_wdata[PRES_W-1:0];
        CFG_WIDE:     wide_w_r   <= cfg_wdata[WEIGHT_W-1:0];
        CFG_SPIKE:    spike_w_r  <= cfg_wdata[WEIGHT_W-1:0];
        CFG_BACK:     back_w_r   <= cfg_wdata[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sensor order across the array, left to right around the back.
  assign samp[0] = in_item.wide_left;
  assign samp[1] = in_item.left_spike;
  assign samp[2] = in_item.left_front;
  assign samp[3] = in_item.rear;
  assign samp[4] = in_item.right_front;
  assign samp[5] = in_item.right_spike;
  assign samp[6] = in_item.wide_right;

  // Bearing magnitudes per lane; the front sensors sit on the axis and carry
  // no weight. The left sign is applied in the merge.
  assign lane_weight[0] = wide_w_r;
  assign lane_weight[1] = spike_w_r;
  assign lane_weight[2] = '0;
  assign lane_weight[3] = back_w_r;
  assign lane_weight[4] = '0;
  assign lane_weight[5] = spike_w_r;
  assign lane_weight[6] = wide_w_r;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    sabc_lane #(
      .CUT_EN (LANE_CUT[g])
    ) u_lane (
      .clk       (clk),
      .sample    (samp[g]),
      .threshold (low_cut_r),
      .weight    (lane_weight[g]),
      .sample_r  (lane_samp[g]),
      .prod_r    (lane_prod[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r <= 1'b0;
    end else begin
      lane_vld_r <= start && !busy;
    end
  end

  sabc_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (lane_vld_r),
    .prod         (lane_prod),
    .samp         (lane_samp),
    .presence_min (presence_r),
    .out_valid    (merge_vld),
    .merge_r      (merge_data)
  );

  sabc_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (merge_vld),
    .in_data   (merge_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Every accepted item yields its result after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("result missing after pipeline latency");

  // An empty scan must report a zero bearing.
  a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.sample_total == '0)) |-> (out_item.bearing == '0))
    else $error("nonzero bearing for zero total");

  // A weighted mean of 10-bit weights never reaches the most negative code.
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.bearing != {1'b1, {(BEARING_W - 1){1'b0}}}))
    else $error("bearing out of range");

endmodule

FILE: hw/rtl/sabc_lane.sv
module sabc_lane #(
  parameter bit CUT_EN = 1'b0
) (
  input  logic                            clk,
  input  logic [sabc_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [sabc_pkg::THRESH_W-1:0]    threshold,
  input  logic [sabc_pkg::WEIGHT_W-1:0]    weight,
  output logic [sabc_pkg::SAMPLE_BITS-1:0] sample_r,
  output logic [sabc_pkg::PROD_W-1:0]      prod_r
);
  import sabc_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_nxt;
  logic [PROD_W-1:0]      prod_nxt;

  // A cut lane drops samples strictly below the threshold.
  always_comb begin
    sample_nxt = sample;
    if (CUT_EN && (TCMP_W'(sample) < TCMP_W'(threshold))) begin
      sample_nxt = '0;
    end
    prod_nxt = PROD_W'(sample_nxt) * PROD_W'(weight);
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    prod_r   <= prod_nxt;
  end

endmodule

FILE: hw/rtl/sabc_merge.sv
module sabc_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [sabc_pkg::PROD_W-1:0]      prod [sabc_pkg::NUM_SENSORS],
  input  logic [sabc_pkg::SAMPLE_BITS-1:0] samp [sabc_pkg::NUM_SENSORS],
  input  logic [sabc_pkg::PRES_W-1:0]      presence_min,
  output logic                             out_valid,
  output sabc_pkg::merge_t                 merge_r
);
  import sabc_pkg::*;

  logic signed [SUM_W-1:0] term [NUM_SENSORS];
  logic signed [SUM_W-1:0] psum_nxt [4];
  logic signed [SUM_W-1:0] psum_r [4];
  logic [TOTAL_W-1:0]      tsum_nxt [4];
  logic [TOTAL_W-1:0]      tsum_r [4];
  logic                    vld_a_r;
  merge_t                  merge_nxt;
  logic signed [SUM_W-1:0] sum_b;
  logic [TOTAL_W-1:0]      total_b;

  // Left lanes carry a negative bearing.
  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      term[i] = $signed({{(SUM_W - PROD_W){1'b0}}, prod[i]});
      if (LANE_NEG[i]) begin
        term[i] = -term[i];
      end
    end
    psum_nxt[0] = term[0] + term[1];
    psum_nxt[1] = term[2] + term[3];
    psum_nxt[2] = term[4] + term[5];
    psum_nxt[3] = term[6];
    tsum_nxt[0] = TOTAL_W'(samp[0]) + TOTAL_W'(samp[1]);
    tsum_nxt[1] = TOTAL_W'(samp[2]) + TOTAL_W'(samp[3]);
    tsum_nxt[2] = TOTAL_W'(samp[4]) + TOTAL_W'(samp[5]);
    tsum_nxt[3] = TOTAL_W'(samp[6]);
  end

  always_comb begin
    sum_b   = psum_r[0] + psum_r[1] + psum_r[2] + psum_r[3];
    total_b = tsum_r[0] + tsum_r[1] + tsum_r[2] + tsum_r[3];
    merge_nxt.sum   = sum_b;
    merge_nxt.total = total_b;
    merge_nxt.seen  = CMP_W'(total_b) > CMP_W'(presence_min);
    if (CMP_W'(total_b) > CMP_W'({OUT_TOTAL_W{1'b1}})) begin
      merge_nxt.total_sat = {OUT_TOTAL_W{1'b1}};
    end else begin
      merge_nxt.total_sat = OUT_TOTAL_W'(total_b);
    end
  end

  always_ff @(posedge clk) begin
    psum_r  <= psum_nxt;
    tsum_r  <= tsum_nxt;
    merge_r <= merge_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a_r   <= in_valid;
      out_valid <= vld_a_r;
    end
  end

endmodule

FILE: hw/rtl/sabc_divider.sv
module sabc_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sabc_pkg::merge_t    in_data,
  output logic                out_valid,
  output sabc_pkg::out_item_t out_item
);
  import sabc_pkg::*;

  div_stage_t                   st_r   [QUOT_W+1];
  div_stage_t                   st_nxt [QUOT_W+1];
  logic                         vld_r  [QUOT_W+1];
  logic [MAG_W-1:0]             dvs    [QUOT_W];
  logic                         take   [QUOT_W];
  logic signed [BEARING_W-1:0]  q_ext;
  out_item_t                    out_nxt;

  // Sign and magnitude split, then one quotient bit per stage, most
  // significant first. The quotient of a weighted mean stays below 2^10,
  // so ten restoring steps suffice.
  always_comb begin
    st_nxt[0].rem       = in_data.sum[SUM_W-1] ? MAG_W'(-in_data.sum) : MAG_W'(in_data.sum);
    st_nxt[0].total     = in_data.total;
    st_nxt[0].nz        = in_data.total != '0;
    st_nxt[0].neg       = in_data.sum[SUM_W-1];
    st_nxt[0].quot      = '0;
    st_nxt[0].seen      = in_data.seen;
    st_nxt[0].total_sat = in_data.total_sat;
    for (int j = 0; j < QUOT_W; j++) begin
      dvs[j]       = MAG_W'(st_r[j].total) << (QUOT_W - 1 - j);
      take[j]      = st_r[j].nz && (st_r[j].rem >= dvs[j]);
      st_nxt[j+1]  = st_r[j];
      if (take[j]) begin
        st_nxt[j+1].rem = st_r[j].rem - dvs[j];
        st_nxt[j+1].quot[QUOT_W-1-j] = 1'b1;
      end
    end
  end

  always_comb begin
    q_ext = $signed({{(BEARING_W - QUOT_W){1'b0}}, st_r[QUOT_W].quot});
    out_nxt.bearing      = st_r[QUOT_W].neg ? -q_ext : q_ext;
    out_nxt.target_seen  = st_r[QUOT_W].seen;
    out_nxt.sample_total = st_r[QUOT_W].total_sat;
  end

  always_ff @(posedge clk) begin
    st_r     <= st_nxt;
    out_item <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QUOT_W; j++) begin
        vld_r[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int j = 0; j < QUOT_W; j++) begin
        vld_r[j+1] <= vld_r[j];
      end
      out_valid <= vld_r[QUOT_W];
    end
  end

endmodule

FILE: tb/centroid_checker.sv
`timescale 1ns / 1ps

// Watches the scan and result channels of the bearing estimator, predicts
// each result from the scan and its own copy of the registers, and checks
// the results in order.
module centroid_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  sabc_pkg::in_item_t               in_item,
  input  logic                             out_valid,
  input  sabc_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [sabc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sabc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               mismatches,
  output int                               outstanding
);
  import sabc_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam longint TOTAL_CEIL = 8191;

  logic [9:0]  cut_level;
  logic [12:0] presence_min;
  logic [9:0]  wide_w;
  logic [9:0]  spike_w;
  logic [9:0]  back_w;

  out_item_t bearing_due[$];

  function automatic out_item_t predict_centroid(in_item_t scan);
    logic [SAMPLE_BITS-1:0] lane [NUM_SENSORS];
    longint weight [NUM_SENSORS];
    longint sample;
    longint moment;
    longint total;
    longint angle;
    out_item_t r;
    lane[0] = scan.wide_left;
    lane[1] = scan.left_spike;
    lane[2] = scan.left_front;
    lane[3] = scan.rear;
    lane[4] = scan.right_front;
    lane[5] = scan.right_spike;
    lane[6] = scan.wide_right;
    weight[0] = -longint'(wide_w);
    weight[1] = -longint'(spike_w);
    weight[2] = 0;
    weight[3] = longint'(back_w);
    weight[4] = 0;
    weight[5] = longint'(spike_w);
    weight[6] = longint'(wide_w);
    moment = 0;
    total  = 0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sample = lane[i];
      // Only the two fronts, the rear and the right spike are cut.
      if (i >= 2 && i <= 5 && sample < cut_level) begin
        sample = 0;
      end
      moment += sample * weight[i];
      total  += sample;
    end
    angle = (total != 0) ? moment / total : 0;
    r.bearing      = angle[BEARING_W-1:0];
    r.target_seen  = (total > longint'(presence_min));
    r.sample_total = (total > TOTAL_CEIL) ? TOTAL_CEIL[OUT_TOTAL_W-1:0]
                                          : total[OUT_TOTAL_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      cut_level    = 10'd93;
      presence_min = 13'd5;
      wide_w       = 10'd246;
      spike_w      = 10'd123;
      back_w       = 10'd804;
      bearing_due.delete();
      outstanding  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_LOW_CUT:  cut_level    = cfg_wdata[9:0];
          CFG_PRESENCE: presence_min = cfg_wdata[12:0];
          CFG_WIDE:     wide_w       = cfg_wdata[9:0];
          CFG_SPIKE:    spike_w      = cfg_wdata[9:0];
          CFG_BACK:     back_w       = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (bearing_due.size() == 0) begin
          note_mismatch($sformatf("result with none expected: bearing %0d seen %0d total %0d",
                                  out_item.bearing, out_item.target_seen,
                                  out_item.sample_total));
        end else begin
          due = bearing_due.pop_front();
          if (out_item.bearing !== due.bearing) begin
            note_mismatch($sformatf("bearing: expected %0d, got %0d",
                                    due.bearing, out_item.bearing));
          end
          if (out_item.target_seen !== due.target_seen) begin
            note_mismatch($sformatf("target_seen: expected %0d, got %0d",
                                    due.target_seen, out_item.target_seen));
          end
          if (out_item.sample_total !== due.sample_total) begin
            note_mismatch($sformatf("sample_total: expected %0d, got %0d",
                                    due.sample_total, out_item.sample_total));
          end
        end
      end
      if (start && !busy) begin
        bearing_due.push_back(predict_centroid(in_item));
      end
      outstanding = bearing_due.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the bearing estimator. The checker beside the
// block does all prediction and comparison; this module only feeds scans,
// programs the registers between phases and decides pass or fail.
module testbench;
  import sabc_pkg::*;

  // Margin allowed after the pipeline drains, before registers change or the run ends.
  localparam int SETTLE_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTINGS_COUNT  = 8;
  localparam int SCANS_PER_SETTING = 216;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;

  // Stimulus-side knowledge of the current cut level, used only to aim
  // samples at the threshold boundary or below it.
  logic [9:0] cur_cut = 10'd93;
  // Chance, in percent, that the sender holds off before a scan.
  int idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sensor_array_bearing_centroid uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  centroid_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The watchdog restarts whenever a scan is taken, a result appears or a register
  // is written; a hang of the scan or result channel runs it out.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_scan(int wl, int ls, int lf, int rr, int rf,
                                         int rs, int wr);
    in_item_t s;
    s.wide_left   = wl[SAMPLE_BITS-1:0];
    s.left_spike  = ls[SAMPLE_BITS-1:0];
    s.left_front  = lf[SAMPLE_BITS-1:0];
    s.rear        = rr[SAMPLE_BITS-1:0];
    s.right_front = rf[SAMPLE_BITS-1:0];
    s.right_spike = rs[SAMPLE_BITS-1:0];
    s.wide_right  = wr[SAMPLE_BITS-1:0];
    return s;
  endfunction

  // Half full-range samples, with extra weight on zero, full scale, small
  // values and the three codes around the current cut level.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 10) begin
      v = 0;
    end else if (roll < 15) begin
      v = SAMPLE_MAX;
    end else if (roll < 35) begin
      v = int'(cur_cut) + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    end else if (roll < 50) begin
      v = $urandom_range(15);
    end else begin
      v = $urandom_range(SAMPLE_MAX);
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic in_item_t random_scan();
    int lane [NUM_SENSORS];
    int shape;
    shape = $urandom_range(99);
    for (int i = 0; i < NUM_SENSORS; i++) begin
      lane[i] = pick_sample();
    end
    if (shape < 4) begin
      // Dark scan: total of zero.
      foreach (lane[i]) lane[i] = 0;
    end else if (shape < 8) begin
      // Outer lanes dark and every cut lane below the cut: also zero.
      lane[0] = 0;
      lane[1] = 0;
      lane[6] = 0;
      for (int i = 2; i <= 5; i++) begin
        lane[i] = (cur_cut == 0) ? 0 : $urandom_range(int'(cur_cut) - 1);
      end
    end
    return make_scan(lane[0], lane[1], lane[2], lane[3], lane[4], lane[5], lane[6]);
  endfunction

  // Called at a falling edge. Start is left high after acceptance so that
  // back-to-back scans never drop it; only an idle cycle or a drain lowers it.
  task automatic send_scan(in_item_t scan);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_item <= random_scan();
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= scan;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Holds the sender off until every scan in flight has produced its result.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  // Writes all five registers on consecutive cycles; called only while the
  // block is idle.
  task automatic load_regs(int cut, int pres, int wide, int spike, int back);
    put_reg(CFG_LOW_CUT, cut);
    put_reg(CFG_PRESENCE, pres);
    put_reg(CFG_WIDE, wide);
    put_reg(CFG_SPIKE, spike);
    put_reg(CFG_BACK, back);
    cfg_we  <= 1'b0;
    cur_cut = cut[9:0];
  endtask

  // One register setting per phase, extremes included.
  task automatic apply_setting(int phase);
    case (phase)
      0: load_regs(93, 5, 246, 123, 804);
      1: load_regs(0, 0, 1023, 1023, 1023);
      2: load_regs(1023, 8191, 0, 0, 0);
      3: load_regs($urandom_range(200), $urandom_range(7161), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(1023));
      4: load_regs(1023, 7161, 1023, 0, 1023);
      5: load_regs(1, 1, 0, 1023, 0);
      6: load_regs($urandom_range(1023), $urandom_range(8191), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(1023));
      default: load_regs(93, 5, 246, 123, 804);
    endcase
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_LOW_CUT;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed scans against the reset register values.
    send_scan(make_scan(0, 0, 0, 0, 0, 0, 0));               // dark scan
    send_scan(make_scan(1023, 1023, 1023, 1023, 1023, 1023, 1023));
    send_scan(make_scan(1023, 0, 0, 0, 0, 0, 0));            // wide left alone
    send_scan(make_scan(0, 0, 0, 0, 0, 0, 1023));            // wide right alone
    send_scan(make_scan(0, 1023, 0, 0, 0, 0, 0));            // left spike alone
    send_scan(make_scan(0, 0, 0, 0, 0, 1023, 0));            // right spike alone
    send_scan(make_scan(0, 0, 0, 1023, 0, 0, 0));            // rear alone
    send_scan(make_scan(0, 0, 1023, 0, 1023, 0, 0));         // fronts weigh nothing
    send_scan(make_scan(0, 0, 92, 92, 92, 92, 0));           // all just under the cut
    send_scan(make_scan(0, 0, 93, 93, 93, 93, 0));           // all exactly at the cut
    send_scan(make_scan(0, 0, 92, 93, 0, 0, 0));
    send_scan(make_scan(5, 0, 0, 0, 0, 0, 0));               // total equals presence minimum
    send_scan(make_scan(6, 0, 0, 0, 0, 0, 0));               // one above it
    send_scan(make_scan(1, 0, 100, 0, 0, 0, 0));             // negative, truncated toward zero
    send_scan(make_scan(0, 0, 100, 0, 0, 0, 1));             // positive, truncated toward zero
    send_scan(make_scan(500, 0, 0, 0, 0, 0, 500));           // left and right cancel
    send_scan(make_scan(1023, 1023, 0, 0, 0, 0, 0));         // wide left and left spike together
    send_scan(make_scan('h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA));
    send_scan(make_scan('h155, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155));
    send_scan(make_scan(1, 1, 1, 1, 1, 1, 1));               // cut lanes vanish
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    // Random phases, each with its own register setting and idle pattern.
    for (int phase = 0; phase < SETTINGS_COUNT; phase++) begin
      apply_setting(phase);
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 64;
        default: idle_pct = 15;
      endcase
      for (int n = 0; n < SCANS_PER_SETTING; n++) begin
        // Halfway through, let the pipeline run dry before going on.
        if (n == SCANS_PER_SETTING / 2) drain();
        send_scan(random_scan());
      end
      drain();
      repeat (SETTLE_CYCLES) @(negedge clk);
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
